[rtl/core/kabf_pkg.sv]
`default_nettype none
package kabf_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned NoiseW = 31;
  localparam int unsigned DtW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivW = 56;
  localparam int unsigned DivCntW = 6;

  localparam logic [NoiseW-1:0] AngleNoiseRst = 31'd16777;
  localparam logic [NoiseW-1:0] BiasNoiseRst = 31'd50332;
  localparam logic [NoiseW-1:0] MeasNoiseRst = 31'd503316;

  localparam logic [CfgIdxW-1:0] RegAngleNoise = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBiasNoise = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMeasNoise = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_RATE, S_ANG, S_DTP, S_P00, S_P11, S_INNOV,
    S_DIV0_GO, S_DIV0, S_DIV1_GO, S_DIV1,
    S_CA, S_CB, S_C00, S_C01, S_C10, S_C11, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic neg;
    logic [DataW-1:0] num_mag;
    logic [DataW:0] den_mag;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic signed [DataW-1:0] gain;
  } div_rsp_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[DataW-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/core/kabf_if.sv]
`default_nettype none
interface kabf_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] measured_rate;
  logic [15:0] time_step;
  modport source (output valid, measured_angle, measured_rate, time_step, input ready);
  modport sink (input valid, measured_angle, measured_rate, time_step, output ready);
endinterface

interface kabf_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] filtered_angle;
  logic signed [31:0] corrected_rate;
  logic signed [31:0] bias_estimate;
  modport source (output valid, filtered_angle, corrected_rate, bias_estimate, input ready);
  modport sink (input valid, filtered_angle, corrected_rate, bias_estimate, output ready);
endinterface
`default_nettype wire

[rtl/core/kabf_div.sv]
`default_nettype none
module kabf_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  kabf_pkg::div_req_t  req,
  output kabf_pkg::div_rsp_t  rsp
);
  localparam int unsigned W = kabf_pkg::DivW;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W:0] rem_r, rem_nxt;
  logic [kabf_pkg::DataW:0] den_r;
  logic neg_r;
  logic [kabf_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic busy_r;
  logic [W:0] trial;
  logic [W-1:0] q_sat;

  always_comb begin
    trial = {rem_r[W-1:0], quo_r[W-1]};
    quo_nxt = {quo_r[W-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {{(W-kabf_pkg::DataW){1'b0}}, den_r}) begin
      rem_nxt = trial - {{(W-kabf_pkg::DataW){1'b0}}, den_r};
      quo_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r <= kabf_pkg::DivCntW'(W);
      quo_r <= {req.num_mag, 24'd0};
      rem_r <= '0;
      den_r <= req.den_mag;
      neg_r <= req.neg;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
      if (cnt_r == kabf_pkg::DivCntW'(1)) busy_r <= 1'b0;
    end
  end

  always_comb begin
    q_sat = (quo_r > W'(64'h80000000)) ? W'(64'h80000000) : quo_r;
    rsp.busy = busy_r;
    rsp.gain = kabf_pkg::sat32(neg_r ? -$signed({12'd0, q_sat}) : $signed({12'd0, q_sat}));
  end
endmodule
`default_nettype wire

[rtl/core/kabf_mul.sv]
`default_nettype none
module kabf_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [33:0] b,
  output logic signed [66:0]      p
);
  logic signed [66:0] p_r;
  always_ff @(posedge clk) p_r <= a * b;
  assign p = p_r;
endmodule
`default_nettype wire

[rtl/core/kalman_angle_bias_filter_core.sv]
// channel   | dir | payload                                            | handshake
// in        | in  | measured_angle, measured_rate, time_step           | valid/ready
// out       | out | filtered_angle, corrected_rate, bias_estimate      | valid/ready
// cfg       | in  | cfg_we, cfg_index, cfg_data                        | write enable
// A request is worked through in ten steps on one shared 33x34 multiplier, five
// further sequencer steps and two divisions that hold the sequencer until the divider
// is no longer busy; a zero innovation variance skips both divisions.
// rst_n is synchronous; state, covariance and registers return to their reset values.
// in_ready is high only in the idle state; a result waits in the output register
// until taken, and the next request is accepted once it has gone.
`default_nettype none
module kalman_angle_bias_filter_core #(
  parameter int unsigned CfgW = kabf_pkg::NoiseW
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  kabf_in_if.sink                  in_ch,
  kabf_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [kabf_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgW-1:0]     cfg_data
);
  typedef logic signed [31:0] w_t;
  kabf_pkg::state_t st_r, st_nxt;
  logic [30:0] qa_r, qb_r, rm_r;
  w_t ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  w_t mang_r, rate_r, y_r, k0_r, k1_r, dtp_r;
  logic [15:0] dt_r;
  logic mphase_r;
  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic signed [66:0] mp;
  logic signed [32:0] s_val;
  kabf_pkg::div_req_t dreq;
  kabf_pkg::div_rsp_t drsp;
  logic ov_r;
  w_t oa_r, orate_r, ob_r;

  kabf_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
  kabf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_ch.ready = (st_r == kabf_pkg::S_IDLE) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.filtered_angle = oa_r;
  assign out_ch.corrected_rate = orate_r;
  assign out_ch.bias_estimate = ob_r;

  assign s_val = 33'(p00_r) + $signed({2'b00, rm_r});

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      kabf_pkg::S_ANG: begin ma = {17'd0, dt_r}; mb = 34'(rate_r); end
      kabf_pkg::S_DTP: begin ma = {17'd0, dt_r}; mb = 34'(p11_r); end
      kabf_pkg::S_P00: begin
        ma = {17'd0, dt_r};
        mb = 34'(dtp_r) - 34'(p01_r) - 34'(p10_r) + $signed({3'b000, qa_r});
      end
      kabf_pkg::S_P11: begin ma = {17'd0, dt_r}; mb = $signed({3'b000, qb_r}); end
      kabf_pkg::S_CA:  begin ma = 33'(k0_r); mb = 34'(y_r); end
      kabf_pkg::S_CB:  begin ma = 33'(k1_r); mb = 34'(y_r); end
      kabf_pkg::S_C00: begin ma = 33'(k0_r); mb = 34'(p00_r); end
      kabf_pkg::S_C01: begin ma = 33'(k0_r); mb = 34'(p01_r); end
      kabf_pkg::S_C10: begin ma = 33'(k1_r); mb = 34'(p00_r); end
      kabf_pkg::S_C11: begin ma = 33'(k1_r); mb = 34'(p01_r); end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    dreq = '0;
    case (st_r)
      kabf_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) st_nxt = kabf_pkg::S_RATE;
      kabf_pkg::S_RATE: st_nxt = kabf_pkg::S_ANG;
      kabf_pkg::S_ANG: if (mphase_r) st_nxt = kabf_pkg::S_DTP;
      kabf_pkg::S_DTP: if (mphase_r) st_nxt = kabf_pkg::S_P00;
      kabf_pkg::S_P00: if (mphase_r) st_nxt = kabf_pkg::S_P11;
      kabf_pkg::S_P11: if (mphase_r) st_nxt = kabf_pkg::S_INNOV;
      kabf_pkg::S_INNOV: st_nxt = (s_val == '0) ? kabf_pkg::S_CA : kabf_pkg::S_DIV0_GO;
      kabf_pkg::S_DIV0_GO: begin
        dreq.start = 1'b1;
        dreq.neg = p00_r[31] ^ s_val[32];
        dreq.num_mag = p00_r[31] ? 32'(-33'(p00_r)) : p00_r;
        dreq.den_mag = s_val[32] ? 33'(-s_val) : 33'(s_val);
        st_nxt = kabf_pkg::S_DIV0;
      end
      kabf_pkg::S_DIV0: if (!drsp.busy) st_nxt = kabf_pkg::S_DIV1_GO;
      kabf_pkg::S_DIV1_GO: begin
        dreq.start = 1'b1;
        dreq.neg = p10_r[31] ^ s_val[32];
        dreq.num_mag = p10_r[31] ? 32'(-33'(p10_r)) : p10_r;
        dreq.den_mag = s_val[32] ? 33'(-s_val) : 33'(s_val);
        st_nxt = kabf_pkg::S_DIV1;
      end
      kabf_pkg::S_DIV1: if (!drsp.busy) st_nxt = kabf_pkg::S_CA;
      kabf_pkg::S_CA: if (mphase_r) st_nxt = kabf_pkg::S_CB;
      kabf_pkg::S_CB: if (mphase_r) st_nxt = kabf_pkg::S_C00;
      kabf_pkg::S_C00: if (mphase_r) st_nxt = kabf_pkg::S_C01;
      kabf_pkg::S_C01: if (mphase_r) st_nxt = kabf_pkg::S_C10;
      kabf_pkg::S_C10: if (mphase_r) st_nxt = kabf_pkg::S_C11;
      kabf_pkg::S_C11: if (mphase_r) st_nxt = kabf_pkg::S_OUT;
      kabf_pkg::S_OUT: st_nxt = kabf_pkg::S_IDLE;
      default: st_nxt = kabf_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= kabf_pkg::S_IDLE;
      mphase_r <= 1'b0;
      ov_r <= 1'b0;
      qa_r <= kabf_pkg::AngleNoiseRst;
      qb_r <= kabf_pkg::BiasNoiseRst;
      rm_r <= kabf_pkg::MeasNoiseRst;
      ang_r <= '0; bias_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          kabf_pkg::RegAngleNoise: qa_r <= cfg_data[30:0];
          kabf_pkg::RegBiasNoise:  qb_r <= cfg_data[30:0];
          kabf_pkg::RegMeasNoise:  rm_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      mphase_r <= 1'b0;
      case (st_r)
        kabf_pkg::S_IDLE: if (in_ch.valid && in_ch.ready) begin
          mang_r <= in_ch.measured_angle;
          rate_r <= in_ch.measured_rate;
          dt_r <= in_ch.time_step;
          k0_r <= '0; k1_r <= '0;
        end
        kabf_pkg::S_RATE: rate_r <= kabf_pkg::sat32(68'(rate_r) - 68'(bias_r));
        kabf_pkg::S_ANG: begin
          mphase_r <= !mphase_r;
          if (mphase_r) ang_r <= kabf_pkg::sat32(68'(ang_r) + 68'(mp >>> 16));
        end
        kabf_pkg::S_DTP: begin
          mphase_r <= !mphase_r;
          if (mphase_r) dtp_r <= w_t'(mp >>> 16);
        end
        kabf_pkg::S_P00: begin
          mphase_r <= !mphase_r;
          if (mphase_r) begin
            p00_r <= kabf_pkg::sat32(68'(p00_r) + 68'(mp >>> 16));
            p01_r <= kabf_pkg::sat32(68'(p01_r) - 68'(dtp_r));
            p10_r <= kabf_pkg::sat32(68'(p10_r) - 68'(dtp_r));
          end
        end
        kabf_pkg::S_P11: begin
          mphase_r <= !mphase_r;
          if (mphase_r) p11_r <= kabf_pkg::sat32(68'(p11_r) + 68'(mp >>> 16));
        end
        kabf_pkg::S_INNOV: y_r <= kabf_pkg::sat32(68'(mang_r) - 68'(ang_r));
        kabf_pkg::S_DIV0: if (!drsp.busy) k0_r <= drsp.gain;
        kabf_pkg::S_DIV1: if (!drsp.busy) k1_r <= drsp.gain;
        kabf_pkg::S_CA: begin
          mphase_r <= !mphase_r;
          if (mphase_r) ang_r <= kabf_pkg::sat32(68'(ang_r) + 68'(mp >>> 24));
        end
        kabf_pkg::S_CB: begin
          mphase_r <= !mphase_r;
          if (mphase_r) bias_r <= kabf_pkg::sat32(68'(bias_r) + 68'(mp >>> 24));
        end
        kabf_pkg::S_C00: begin
          mphase_r <= !mphase_r;
          if (mphase_r) dtp_r <= kabf_pkg::sat32(68'(p00_r) - 68'(mp >>> 24));
        end
        kabf_pkg::S_C01: begin
          mphase_r <= !mphase_r;
          if (mphase_r) y_r <= kabf_pkg::sat32(68'(p01_r) - 68'(mp >>> 24));
        end
        kabf_pkg::S_C10: begin
          mphase_r <= !mphase_r;
          if (mphase_r) p10_r <= kabf_pkg::sat32(68'(p10_r) - 68'(mp >>> 24));
        end
        kabf_pkg::S_C11: begin
          mphase_r <= !mphase_r;
          if (mphase_r) p11_r <= kabf_pkg::sat32(68'(p11_r) - 68'(mp >>> 24));
        end
        kabf_pkg::S_OUT: begin
          p00_r <= dtp_r;
          p01_r <= y_r;
          ov_r <= 1'b1;
          oa_r <= ang_r;
          orate_r <= rate_r;
          ob_r <= bias_r;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/core/kabf_checker.sv]
`default_nettype none
module kabf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_angle
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after request");
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##1 !out_valid) else $error("result too early");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_angle))
    else $error("result dropped");
endmodule

bind kalman_angle_bias_filter_core kabf_checker u_kabf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_angle(out_ch.filtered_angle)
);
`default_nettype wire
